FILE: hdl/bfscd_pkg.sv
// shared types and constants for the bfs undirected cycle detector
// no dependencies
`default_nettype none
package bfscd_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned VC_W   = 7;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_RUN    = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] neighbour;
  } in_t;

  typedef struct packed {
    logic cycle_found;
    logic load_error;
  } out_t;

endpackage
`default_nettype wire

FILE: hdl/bfscd_ram.sv
// simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none
module bfscd_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/bfs_undirected_cycle_detect.sv
// top level of the bfs undirected cycle detector: loader, search sequencer
// depends on bfscd_pkg and bfscd_ram
`default_nettype none
// Append transactions (cmd 0) are taken one per cycle while the sequencer
// is idle, and write the entry store and the row table directly. A run
// transaction (cmd 1) starts the search sequencer, which holds in_stall_o
// high until the result is registered: it steps through the root vertices,
// searches from each unvisited one by taking vertices off its queue and
// examining each of their adjacency entries, and then registers the result;
// the single read port of each ram sets this pace.
// A run is held off while the previous result has not been taken.
module bfs_undirected_cycle_detect #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_ENTRIES  = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire bfscd_pkg::in_t   in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      bfscd_pkg::out_t  out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [6:0]       cfg_data_i
);
  import bfscd_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW = $clog2(MAX_ENTRIES);
  localparam int unsigned LW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = EW + 1;
  localparam int unsigned RW = EW + LW;
  localparam int unsigned QW = VW + VW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_DEQ, S_QRD, S_ROW, S_EDGE, S_CHK, S_DONE
  } state_e;

  state_e            state_q;
  logic [VC_W-1:0]   vc_q;
  logic [LW-1:0]     total_q;
  logic [NODE_W-1:0] last_q;
  logic              err_q;
  logic              cur_valid_q;
  logic [EW-1:0]     cur_first_q;
  logic [LW-1:0]     cur_len_q;
  logic [MAX_VERTICES-1:0] row_valid_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [CW-1:0]     root_q, head_q, tail_q;
  logic [VW-1:0]     v_q;
  logic [VW:0]       p_q;
  logic [LW-1:0]     k_q, len_q;
  logic [SW-1:0]     slot_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [CW-1:0]     nv;
  logic              accept, bad;
  logic [EW-1:0]     new_first;
  logic [LW-1:0]     new_len;

  logic              ent_we;
  logic [NODE_W-1:0] ent_rdata;
  logic              row_we;
  logic [RW-1:0]     row_rdata;
  logic              q_we;
  logic [VW-1:0]     q_waddr;
  logic [QW-1:0]     q_wdata, q_rdata;

  logic [VW-1:0]     w_idx, root_idx;
  logic              w_in_range;

  assign nv = (32'(vc_q) < MAX_VERTICES) ? CW'(vc_q) : CW'(MAX_VERTICES);

  assign in_stall_o = (state_q != S_IDLE) ||
                      (out_valid_q && (in_data_i.cmd == CMD_RUN));
  assign accept     = in_valid_i && !in_stall_o;

  assign bad = (32'(total_q) >= MAX_ENTRIES) || (in_data_i.node < last_q) ||
               (32'(in_data_i.node) >= 32'(nv)) ||
               (32'(in_data_i.neighbour) >= 32'(nv));

  // entries of one row arrive together, so only the open row needs counting
  always_comb begin
    if (cur_valid_q && (in_data_i.node == last_q)) begin
      new_first = cur_first_q;
      new_len   = cur_len_q + LW'(1);
    end else begin
      new_first = total_q[EW-1:0];
      new_len   = LW'(1);
    end
  end

  assign ent_we = accept && (in_data_i.cmd == CMD_APPEND) && !bad;
  assign row_we = ent_we;

  assign w_idx      = VW'(ent_rdata);
  assign w_in_range = 32'(ent_rdata) < 32'(nv);
  assign root_idx   = root_q[VW-1:0];

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail_q[VW-1:0];
    q_wdata = {w_idx, 1'b0, v_q};
    if (state_q == S_ROOT) begin
      q_we    = (root_q < nv) && !visited_q[root_idx];
      q_waddr = '0;
      q_wdata = {root_idx, 1'b1, VW'(0)};
    end else if (state_q == S_CHK) begin
      q_we = w_in_range && !visited_q[w_idx] && (32'(tail_q) < MAX_VERTICES);
    end
  end

  bfscd_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(NODE_W)) u_entry (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (total_q[EW-1:0]),
    .wdata_i (in_data_i.neighbour),
    .raddr_i (slot_q[EW-1:0]),
    .rdata_o (ent_rdata)
  );

  bfscd_ram #(.DEPTH(MAX_VERTICES), .WIDTH(RW)) u_row (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (VW'(in_data_i.node)),
    .wdata_i ({new_first, new_len}),
    .raddr_i (q_rdata[QW-1 -: VW]),
    .rdata_o (row_rdata)
  );

  bfscd_ram #(.DEPTH(MAX_VERTICES), .WIDTH(QW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q[VW-1:0]),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vc_q        <= VC_W'(1);
      total_q     <= '0;
      last_q      <= '0;
      err_q       <= 1'b0;
      cur_valid_q <= 1'b0;
      cur_first_q <= '0;
      cur_len_q   <= '0;
      row_valid_q <= '0;
      visited_q   <= '0;
      root_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      v_q         <= '0;
      p_q         <= '0;
      k_q         <= '0;
      len_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.cmd == CMD_RUN) begin
              visited_q     <= '0;
              root_q        <= '0;
              out_q.cycle_found <= 1'b0;
              state_q       <= S_ROOT;
            end else if (bad) begin
              err_q <= 1'b1;
            end else begin
              row_valid_q[VW'(in_data_i.node)] <= 1'b1;
              cur_valid_q <= 1'b1;
              cur_first_q <= new_first;
              cur_len_q   <= new_len;
              last_q      <= in_data_i.node;
              total_q     <= total_q + LW'(1);
            end
          end
        end
        S_ROOT: begin
          if (root_q >= nv) begin
            state_q <= S_DONE;
          end else if (visited_q[root_idx]) begin
            root_q <= root_q + CW'(1);
          end else begin
            visited_q[root_idx] <= 1'b1;
            head_q  <= '0;
            tail_q  <= CW'(1);
            state_q <= S_DEQ;
          end
        end
        S_DEQ: begin
          if (head_q == tail_q) begin
            root_q  <= root_q + CW'(1);
            state_q <= S_ROOT;
          end else begin
            head_q  <= head_q + CW'(1);
            state_q <= S_QRD;
          end
        end
        S_QRD: begin
          v_q     <= q_rdata[QW-1 -: VW];
          p_q     <= q_rdata[VW:0];
          state_q <= S_ROW;
        end
        S_ROW: begin
          k_q     <= '0;
          len_q   <= row_valid_q[v_q] ? row_rdata[LW-1:0] : '0;
          slot_q  <= SW'(row_rdata[RW-1 -: EW]);
          state_q <= S_EDGE;
        end
        S_EDGE: begin
          if ((k_q == len_q) || (32'(slot_q) >= MAX_ENTRIES)) begin
            state_q <= S_DEQ;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          k_q     <= k_q + LW'(1);
          slot_q  <= slot_q + SW'(1);
          state_q <= S_EDGE;
          if (!w_in_range) begin
            err_q <= 1'b1;
          end else if (!visited_q[w_idx]) begin
            visited_q[w_idx] <= 1'b1;
            if (32'(tail_q) < MAX_VERTICES) begin
              tail_q <= tail_q + CW'(1);
            end
          end else if (p_q[VW] || (w_idx != p_q[VW-1:0])) begin
            out_q.cycle_found <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          out_q.load_error <= err_q;
          out_valid_q <= 1'b1;
          row_valid_q <= '0;
          cur_valid_q <= 1'b0;
          total_q     <= '0;
          last_q      <= '0;
          err_q       <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: bench/bfscd_checker.sv
// checker for the bfs undirected cycle detector: predicts each run result
// from the accepted transactions and compares it; depends on bfscd_pkg
`timescale 1ns / 100ps
module bfscd_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  bfscd_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  bfscd_pkg::out_t out_data_i,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_data_i,
  output int              fail_count_o,
  output int              pending_o
);
  import bfscd_pkg::*;

  localparam int NV_MAX = 64;
  localparam int NE_MAX = 256;

  logic [6:0] vcount;
  logic [5:0] store [NE_MAX];
  int         row_start [NV_MAX];
  int         row_len [NV_MAX];
  bit         seen [NV_MAX];
  int         bq_node [NV_MAX];
  int         bq_par [NV_MAX];
  int         n_entries;
  int         last_row;
  bit         err;
  out_t       exp_fifo [256];
  int         exp_wr;
  int         exp_rd;

  assign pending_o = exp_wr - exp_rd;

  function automatic bit bfs_hits_cycle(int root, int nv);
    int head, tail, v, p, slot, w;
    head = 0;
    tail = 1;
    bq_node[0] = root;
    bq_par[0] = -1;
    seen[root] = 1;
    while (head < tail) begin
      v = bq_node[head];
      p = bq_par[head];
      head++;
      for (int k = 0; k < row_len[v]; k++) begin
        slot = row_start[v] + k;
        if (slot >= NE_MAX) break;
        w = store[slot];
        if (w >= nv) begin
          err = 1;
          continue;
        end
        if (!seen[w]) begin
          if (tail < NV_MAX) begin
            bq_node[tail] = w;
            bq_par[tail] = v;
            tail++;
          end
          seen[w] = 1;
        end else if (w != p) begin
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic void absorb(in_t t);
    int nv;
    bit cyc;
    out_t r;
    nv = (vcount < NV_MAX) ? vcount : NV_MAX;
    if (t.cmd == CMD_APPEND) begin
      if (n_entries >= NE_MAX || t.node < last_row ||
          t.node >= nv || t.neighbour >= nv) begin
        err = 1;
        return;
      end
      if (row_len[t.node] == 0) row_start[t.node] = n_entries;
      store[n_entries] = t.neighbour;
      row_len[t.node]++;
      n_entries++;
      last_row = t.node;
    end else begin
      cyc = 0;
      for (int i = 0; i < NV_MAX; i++) seen[i] = 0;
      for (int i = 0; i < nv && !cyc; i++)
        if (!seen[i]) cyc = bfs_hits_cycle(i, nv);
      r.cycle_found = cyc;
      r.load_error = err;
      exp_fifo[exp_wr[7:0]] = r;
      exp_wr++;
      for (int i = 0; i < NV_MAX; i++) row_len[i] = 0;
      n_entries = 0;
      last_row = 0;
      err = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      vcount = 7'd1;
      for (int i = 0; i < NV_MAX; i++) row_len[i] = 0;
      n_entries = 0;
      last_row = 0;
      err = 0;
      fail_count_o = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (cfg_we_i) vcount = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (exp_wr == exp_rd) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %b", out_data_i);
        end else begin
          e = exp_fifo[exp_rd[7:0]];
          exp_rd++;
          if (e.cycle_found !== out_data_i.cycle_found ||
              e.load_error !== out_data_i.load_error) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch: cycle exp %b got %b, error exp %b got %b",
                       e.cycle_found, out_data_i.cycle_found,
                       e.load_error, out_data_i.load_error);
          end
        end
      end
      if (in_valid_i && !in_stall_i) absorb(in_data_i);
    end
  end
endmodule

FILE: bench/tb.sv
// stimulus and verdict for the bfs undirected cycle detector
// depends on bfscd_pkg, bfs_undirected_cycle_detect and bfscd_checker
`timescale 1ns / 100ps
module tb;
  import bfscd_pkg::*;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 0;
  out_t       out_data;
  logic       cfg_we = 0;
  logic [6:0] cfg_data = 7'd1;
  int         fails;
  int         pending;
  int         gap_pct = 0;
  int         stall_pct = 0;
  bit         hold_off = 0;
  int         idle_cycles = 0;
  int         vsize = 1;
  int         items = 0;
  int         phase_end;

  always #4 clk = ~clk;

  bfs_undirected_cycle_detect dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data)
  );

  bfscd_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending)
  );

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays high from one transaction to the next unless a gap is drawn
  task automatic send(logic c, logic [5:0] n, logic [5:0] w);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: c, node: n, neighbour: w};
    items++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_vertices(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vsize = (v > 64) ? 64 : v;
  endtask

  // random graph: sorted rows, mostly well-formed and in range
  task automatic random_graph(int n_items);
    int row;
    int nb;
    row = 0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(3) == 0 && row < vsize - 1) row = $urandom_range(vsize - 1, row);
      nb = (vsize > 0) ? $urandom_range(vsize - 1) : 0;
      if ($urandom_range(19) == 0) send(CMD_APPEND, 6'($urandom), 6'($urandom));
      else send(CMD_APPEND, 6'(row), 6'(nb));
    end
    send(CMD_RUN, 6'($urandom), 6'($urandom));
  endtask

  task automatic tree_graph();
    // symmetric edges of a random tree, optionally one extra edge
    int par [64];
    bit extra;
    extra = $urandom_range(1);
    for (int i = 1; i < vsize; i++) par[i] = $urandom_range(i - 1);
    for (int n = 0; n < vsize; n++) begin
      if (n > 0) send(CMD_APPEND, 6'(n), 6'(par[n]));
      for (int c = n + 1; c < vsize; c++)
        if (par[c] == n) send(CMD_APPEND, 6'(n), 6'(c));
      if (extra && n == vsize - 1 && vsize > 2) send(CMD_APPEND, 6'(n), 0);
    end
    send(CMD_RUN, 0, 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset register value, run on empty store, extremes
    send(CMD_RUN, 6'h3f, 6'h3f);
    set_vertices(7'd0);
    send(CMD_APPEND, 0, 0);
    send(CMD_RUN, 0, 0);
    set_vertices(7'd127);
    send(CMD_APPEND, 0, 1);
    send(CMD_APPEND, 1, 0);
    send(CMD_APPEND, 1, 2);
    send(CMD_APPEND, 2, 1);
    send(CMD_APPEND, 63, 63);
    send(CMD_RUN, 0, 0);
    send(CMD_APPEND, 5, 6);
    send(CMD_APPEND, 3, 4);
    send(CMD_RUN, 0, 0);
    send(CMD_APPEND, 0, 1);
    send(CMD_APPEND, 1, 2);
    send(CMD_APPEND, 2, 0);
    send(CMD_RUN, 0, 0);
    set_vertices(7'd4);
    send(CMD_APPEND, 2, 63);
    send(CMD_APPEND, 42, 1);
    send(CMD_RUN, 0, 0);
    // store overflow
    set_vertices(7'd64);
    for (int i = 0; i < 260; i++) send(CMD_APPEND, 6'(i / 5), 6'($urandom));
    send(CMD_RUN, 0, 0);
    // out of range on run after lowering the vertex count
    send(CMD_APPEND, 0, 40);
    send(CMD_APPEND, 1, 2);
    set_vertices(7'd8);
    send(CMD_RUN, 0, 0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 56; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 56; end
        3: begin gap_pct = 27; stall_pct = 27; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      phase_end = items + 230;
      for (int g = 0; items < phase_end; g++) begin
        if (g % 3 == 0) set_vertices((ph == 4) ? 7'd64 : 7'($urandom_range(127)));
        if (ph == 2 && g == 0) begin
          // long receiver hold-off while runs keep coming
          hold_off = 1;
          fork
            begin repeat (3000) @(posedge clk); hold_off = 0; end
          join_none
          random_graph(4);
          random_graph(4);
        end
        if ($urandom_range(1)) tree_graph();
        else random_graph($urandom_range(12));
      end
    end
    // sender pause until all results are in, then a final random burst
    drain();
    set_vertices(7'd1);
    send(CMD_APPEND, 0, 0);
    send(CMD_RUN, 0, 0);
    for (int g = 0; g < 20; g++) begin
      if (g % 10 == 0) set_vertices(7'($urandom_range(3, 70)));
      random_graph($urandom_range(6, 20));
    end
    drain();
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
